[design/klt_pkg.sv]
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types and constants of the keyword and literal tokenizer: keyword
// texts, result kinds, character codes and prefix classes.
// ----------------------------------------------------------------------------
package klt_pkg;

   localparam int KW_COUNT   = 22;
   localparam int KW_MAX_LEN = 6;

   // keyword texts, left aligned and padded with spaces
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "defun ", "return", "+     ", "-     ", "*     ", "/     ",
      "%     ", "and   ", "or    ", "not   ", "lt    ", "le    ",
      "eq    ", "ge    ", "gt    ", "if    ", "else  ", "endif ",
      "drop  ", "dup   ", "swap  ", "rot   "
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd6, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd5,
      3'd4, 3'd3, 3'd4, 3'd3
   };

   localparam logic [4:0] KIND_ARG     = 5'd22;
   localparam logic [4:0] KIND_LITERAL = 5'd23;
   localparam logic [4:0] KIND_IDENT   = 5'd24;
   localparam logic [4:0] KIND_BROKEN  = 5'd25;
   localparam logic [4:0] KIND_END     = 5'd26;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_X     = 8'h78;

   typedef enum logic [7:0] {
      PC_IDENT    = 8'b0000_0001,
      PC_ARPREFIX = 8'b0000_0010,
      PC_ARG      = 8'b0000_0100,
      PC_MINUS    = 8'b0000_1000,
      PC_NEG      = 8'b0001_0000,
      PC_DEC      = 8'b0010_0000,
      PC_HEX      = 8'b0100_0000,
      PC_BROKEN   = 8'b1000_0000
   } prefix_class_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type n;
      n.ok    = 1'b1;
      n.value = 4'd0;
      if (c inside {["0":"9"]}) begin
         n.value = c[3:0];
      end else if (c inside {["a":"f"], ["A":"F"]}) begin
         n.value = c[3:0] + 4'd9;
      end else begin
         n.ok = 1'b0;
      end
      return n;
   endfunction

endpackage

[design/klt_if.sv]
// ----------------------------------------------------------------------------
// klt_if
// Valid/ready channel interfaces of the tokenizer: source bytes in, token
// results out.
// ----------------------------------------------------------------------------
interface klt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       input_ends;

   modport source(output valid, source_byte, input_ends, input ready);
   modport sink(input valid, source_byte, input_ends, output ready);
endinterface

interface klt_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         token_kind;
   logic signed [31:0] literal_number;
   logic signed [31:0] argument_index;
   logic [7:0]         token_length;
   logic               too_long;
   logic [15:0]        source_line;

   modport source(output valid, token_kind, literal_number, argument_index,
                  token_length, too_long, source_line, input ready);
   modport sink(input valid, token_kind, literal_number, argument_index,
                token_length, too_long, source_line, output ready);
endinterface

[design/keyword_literal_tokenizer.sv]
// ----------------------------------------------------------------------------
// keyword_literal_tokenizer
// Byte-serial tokenizer: splits source text at white space, skips comments,
// counts lines and classifies each token as keyword, arg, literal, ident,
// broken or end marker.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   req_chan  in         source_byte, input_ends
//   rsp_chan  out        token_kind, literal_number, argument_index,
//                        token_length, too_long, source_line
//
// one byte per cycle sustained while the result register is not stalled; a
// byte is held in the input register, its state update and result are formed
// there and land in the result register, where a token result then shows.
// synchronous reset clears the token, comment and line state.
// a stalled result register holds the input register, which once full holds req.
// ----------------------------------------------------------------------------
module keyword_literal_tokenizer #(
   parameter int MAX_TOKEN_CHARS = 255
) (
   input logic      clock,
   input logic      reset,
   klt_req_if.sink   req_chan,
   klt_rsp_if.source rsp_chan
);
   import klt_pkg::*;

   localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TOKEN_CHARS);
   localparam logic [7:0] LEN_SAT = (MAX_TOKEN_CHARS > 255) ? 8'hff : 8'(MAX_TOKEN_CHARS);

   // input register
   logic       hold_vld_ff, hold_vld_in;
   logic [7:0] hold_byte_ff;
   logic       hold_ends_ff;

   // token state
   logic                  in_token_ff, in_token_in;
   logic                  comment_ff, comment_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [KW_COUNT-1:0]   cand_ff, cand_in;
   prefix_class_type      pclass_ff, pclass_in;
   logic                  digits_ff, digits_in;
   logic [31:0]           acc_ff, acc_in;
   logic [15:0]           lines_ff, lines_in;
   logic                  ovf_ff, ovf_in;

   // result register
   logic        out_vld_ff, out_vld_in;
   logic [4:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_lit_ff, out_lit_in;
   logic [31:0] out_arg_ff, out_arg_in;
   logic [7:0]  out_len_ff, out_len_in;
   logic        out_long_ff, out_long_in;
   logic [15:0] out_line_ff, out_line_in;

   logic advance, fire, res_fire;

   // take-character results
   logic [KW_COUNT-1:0] tk_cand;
   prefix_class_type    tk_pclass;
   logic                tk_digits;
   logic [31:0]         tk_acc;
   logic [CW-1:0]       tk_count;
   logic                tk_ovf;

   // emit results
   logic [4:0]    em_kind;
   logic [31:0]   em_lit, em_arg;
   logic [7:0]    em_len;
   logic [CW+7:0] cnt_ext;

   logic [7:0]  c;
   logic [3:0]  dig;
   logic        is_dig, sep, is_lf;
   logic [31:0] acc10;
   logic [2:0]  pos3;
   nibble_type  nib;

   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !hold_vld_ff || advance;
   assign fire           = hold_vld_ff && advance;

   assign c      = hold_byte_ff;
   assign dig    = c[3:0];
   assign is_dig = c inside {["0":"9"]};
   assign is_lf  = (c == CH_LF);
   assign sep    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || is_lf;
   assign acc10  = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + 32'(dig);
   assign pos3   = (count_ff < CW'(KW_MAX_LEN)) ? count_ff[2:0] : 3'd0;
   assign nib    = hex_nibble(c);

   // next token state after taking one character
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         tk_cand[k] = cand_ff[k];
         if ((count_ff >= CW'(KW_LEN[k])) ||
             (KW_TEXT[k][8*KW_MAX_LEN-1 - 8*pos3 -: 8] != c)) begin
            tk_cand[k] = 1'b0;
         end
      end
      tk_pclass = pclass_ff;
      tk_digits = digits_ff;
      tk_acc    = acc_ff;
      if (count_ff == '0) begin
         tk_digits = 1'b1;
         tk_acc    = 32'd0;
         if (c == CH_A) begin
            tk_pclass = PC_ARPREFIX;
         end else if (c == CH_MINUS) begin
            tk_pclass = PC_MINUS;
         end else if (is_dig) begin
            tk_pclass = PC_DEC;
            tk_acc    = 32'(dig);
         end else begin
            tk_pclass = PC_IDENT;
         end
      end else begin
         case (pclass_ff)
            PC_ARPREFIX: begin
               if (count_ff == CW'(1) && c == CH_R) begin
                  tk_pclass = PC_ARPREFIX;
               end else if (count_ff == CW'(2) && c == CH_G) begin
                  tk_pclass = PC_ARG;
               end else begin
                  tk_pclass = PC_IDENT;
               end
            end
            PC_ARG, PC_NEG: begin
               if (digits_ff && is_dig) tk_acc = acc10;
               else tk_digits = 1'b0;
            end
            PC_MINUS: begin
               if (is_dig) begin
                  tk_pclass = PC_NEG;
                  tk_acc    = 32'(dig);
               end else begin
                  tk_pclass = PC_BROKEN;
               end
            end
            PC_DEC: begin
               if (count_ff == CW'(1) && c == CH_X && acc_ff == 32'd0) begin
                  tk_pclass = PC_HEX;
               end else if (digits_ff && is_dig) begin
                  tk_acc = acc10;
               end else begin
                  tk_digits = 1'b0;
               end
            end
            PC_HEX: begin
               if (digits_ff && nib.ok) tk_acc = {acc_ff[27:0], nib.value};
               else tk_digits = 1'b0;
            end
            default: begin
            end
         endcase
      end
      tk_count = count_ff;
      tk_ovf   = ovf_ff;
      if (count_ff < MAX_CNT) tk_count = count_ff + CW'(1);
      else tk_ovf = 1'b1;
   end

   // classification of the pending token
   always_comb begin
      logic hit;
      hit     = 1'b0;
      em_kind = KIND_IDENT;
      em_lit  = '1;
      em_arg  = '1;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (!ovf_ff && cand_ff[k] && (CW'(KW_LEN[k]) == count_ff)) begin
            hit     = 1'b1;
            em_kind = 5'(k);
         end
      end
      if (!hit) begin
         case (pclass_ff)
            PC_ARG: begin
               em_kind = KIND_ARG;
               em_arg  = acc_ff;
            end
            PC_NEG: begin
               em_kind = KIND_LITERAL;
               em_lit  = 32'd0 - acc_ff;
            end
            PC_DEC, PC_HEX: begin
               em_kind = KIND_LITERAL;
               em_lit  = acc_ff;
            end
            PC_MINUS, PC_BROKEN: em_kind = KIND_BROKEN;
            default: em_kind = KIND_IDENT;
         endcase
      end
      cnt_ext = (CW+8)'(count_ff);
      em_len  = (cnt_ext > (CW+8)'(255)) ? 8'hff : cnt_ext[7:0];
   end

   // per-transaction state update
   always_comb begin
      logic clr;
      clr         = 1'b0;
      res_fire    = 1'b0;
      in_token_in = in_token_ff;
      comment_in  = comment_ff;
      count_in    = count_ff;
      cand_in     = cand_ff;
      pclass_in   = pclass_ff;
      digits_in   = digits_ff;
      acc_in      = acc_ff;
      lines_in    = lines_ff;
      ovf_in      = ovf_ff;
      out_kind_in = em_kind;
      out_lit_in  = em_lit;
      out_arg_in  = em_arg;
      out_len_in  = em_len;
      out_long_in = ovf_ff;
      out_line_in = lines_ff;
      if (fire) begin
         if (hold_ends_ff) begin
            comment_in = 1'b0;
            res_fire   = 1'b1;
            clr        = 1'b1;
            if (!in_token_ff) begin
               out_kind_in = KIND_END;
               out_lit_in  = '1;
               out_arg_in  = '1;
               out_len_in  = 8'd0;
               out_long_in = 1'b0;
            end
         end else begin
            if (is_lf) lines_in = lines_ff + 16'd1;
            out_line_in = lines_in;
            if (comment_ff) begin
               if (is_lf) comment_in = 1'b0;
            end else if (in_token_ff && sep) begin
               res_fire = 1'b1;
               clr      = 1'b1;
            end else if (in_token_ff || (!sep && c != CH_SEMI)) begin
               in_token_in = 1'b1;
               count_in    = tk_count;
               cand_in     = tk_cand;
               pclass_in   = tk_pclass;
               digits_in   = tk_digits;
               acc_in      = tk_acc;
               ovf_in      = tk_ovf;
            end else if (!sep) begin
               comment_in = 1'b1;
            end
         end
      end
      if (clr) begin
         in_token_in = 1'b0;
         count_in    = '0;
         cand_in     = '1;
         pclass_in   = PC_IDENT;
         digits_in   = 1'b0;
         acc_in      = 32'd0;
         ovf_in      = 1'b0;
      end
   end

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (req_chan.ready) hold_vld_in = req_chan.valid;
      out_vld_in = out_vld_ff;
      if (fire) out_vld_in = res_fire;
      else if (rsp_chan.ready) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         in_token_ff <= 1'b0;
         comment_ff  <= 1'b0;
         count_ff    <= '0;
         cand_ff     <= '1;
         pclass_ff   <= PC_IDENT;
         digits_ff   <= 1'b0;
         acc_ff      <= 32'd0;
         lines_ff    <= 16'd0;
         ovf_ff      <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
         in_token_ff <= in_token_in;
         comment_ff  <= comment_in;
         count_ff    <= count_in;
         cand_ff     <= cand_in;
         pclass_ff   <= pclass_in;
         digits_ff   <= digits_in;
         acc_ff      <= acc_in;
         lines_ff    <= lines_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         hold_byte_ff <= req_chan.source_byte;
         hold_ends_ff <= req_chan.input_ends;
      end
      if (fire && res_fire) begin
         out_kind_ff <= out_kind_in;
         out_lit_ff  <= out_lit_in;
         out_arg_ff  <= out_arg_in;
         out_len_ff  <= out_len_in;
         out_long_ff <= out_long_in;
         out_line_ff <= out_line_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.token_kind     = out_kind_ff;
   assign rsp_chan.literal_number = out_lit_ff;
   assign rsp_chan.argument_index = out_arg_ff;
   assign rsp_chan.token_length   = out_len_ff;
   assign rsp_chan.too_long       = out_long_ff;
   assign rsp_chan.source_line    = out_line_ff;

   // end of input always yields a result
   a_ends_result: assert property (@(posedge clock) disable iff (reset)
      fire && hold_ends_ff |=> out_vld_ff)
      else $error("end of input produced no result");

   // overlong tokens report the saturated length
   a_long_len: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_long_ff |-> out_len_ff == LEN_SAT)
      else $error("too_long with unsaturated length");

   // end marker carries empty length and no values
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_kind_ff == KIND_END |->
         out_len_ff == 8'd0 && !out_long_ff && out_lit_ff == '1 && out_arg_ff == '1)
      else $error("end marker fields wrong");

   // a comment never coexists with a pending token
   a_comment_token: assert property (@(posedge clock) disable iff (reset)
      comment_ff |-> !in_token_ff && count_ff == '0)
      else $error("comment state overlaps token state");

endmodule
